// ===== rtl/core/utf8_stream_decoder_assert.svh =====
// Assertion macros for the UTF-8 stream decoder RTL, used by u8sd_back.
// Depends on nothing; files that check their own logic include it.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTH
// Check that prop holds at every rising clock edge outside reset.
`define U8SD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u8sd assertion failed");
// Check that cond never holds at a rising clock edge outside reset.
`define U8SD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("u8sd forbidden condition seen");
`else
`define U8SD_ASSERT(lbl, clk, rst_n, prop)
`define U8SD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== rtl/core/u8sd_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// Used by every module under rtl/core; depends on nothing.
package u8sd_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_LEN2    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3    = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN4    = 21'h010000;

    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_BAD
    } byte_class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } byte_item_t;

    typedef struct packed {
        logic [CP_W-1:0] char_code;
        logic            has_char;
        logic            string_error;
        logic            string_done;
    } char_item_t;

    // Classified byte as it sits in the queue: payload bits already masked.
    typedef struct packed {
        byte_class_t cls;
        logic [6:0]  payload;
        logic        last;
    } queue_item_t;

    typedef struct packed {
        logic        valid;
        queue_item_t item;
    } queue_head_t;

endpackage

// ===== rtl/core/u8sd_front.sv =====
// Front end: take byte transfers and classify each byte for the queue.
// Depends on u8sd_pkg.
module u8sd_front (
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  u8sd_pkg::byte_item_t   byte_item,
    input  logic                   queue_full,
    output logic                   push,
    output u8sd_pkg::queue_item_t  push_item
);
    import u8sd_pkg::*;

    logic [7:0] b;

    assign b          = byte_item.data_byte;
    assign byte_ready = !queue_full;
    assign push       = byte_valid && !queue_full;

    always_comb
    begin
        push_item.last    = byte_item.end_of_string;
        push_item.payload = 7'd0;
        push_item.cls     = CLS_BAD;
        if (!b[7])
        begin
            push_item.cls     = CLS_ASCII;
            push_item.payload = b[6:0];
        end
        else if (b[7:6] == 2'b10)
        begin
            push_item.cls     = CLS_CONT;
            push_item.payload = {1'b0, b[5:0]};
        end
        else if (b[7:5] == 3'b110)
        begin
            push_item.cls     = CLS_LEAD2;
            push_item.payload = {2'b00, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            push_item.cls     = CLS_LEAD3;
            push_item.payload = {3'b000, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            push_item.cls     = CLS_LEAD4;
            push_item.payload = {4'b0000, b[2:0]};
        end
    end

endmodule

// ===== rtl/core/u8sd_queue.sv =====
// Short FIFO of classified bytes between the front and back ends.
// Depends on u8sd_pkg.
module u8sd_queue #(
    parameter int DEPTH = u8sd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  u8sd_pkg::queue_item_t  push_item,
    output logic                   full,
    input  logic                   pop,
    output u8sd_pkg::queue_head_t  head
);
    import u8sd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/u8sd_back.sv =====
// Back end: decode queued bytes, check sequences, hold the result register.
// Depends on u8sd_pkg and utf8_stream_decoder_assert.svh.
`include "utf8_stream_decoder_assert.svh"

module u8sd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  u8sd_pkg::queue_head_t  head,
    output logic                   pop,
    output logic                   char_valid,
    input  logic                   char_ready,
    output u8sd_pkg::char_item_t   char_item
);
    import u8sd_pkg::*;

    logic [CP_W-1:0] pv_reg, pv_next;
    logic [2:0]      len_reg, len_next;
    logic [1:0]      rem_reg, rem_next;
    logic            err_reg, err_next;
    char_item_t      out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    queue_item_t     q;
    logic [CP_W-1:0] pv_shift;
    logic [CP_W-1:0] min_cp;
    logic            range_ok;
    logic            have;
    logic [CP_W-1:0] cp;
    logic            err_step;

    assign q        = head.item;
    assign pop      = head.valid && (!out_valid_reg || char_ready);
    assign pv_shift = {pv_reg[CP_W-7:0], q.payload[5:0]};

    always_comb
    begin
        case (len_reg)
            SEQ_LEN2: min_cp = MIN_LEN2;
            SEQ_LEN3: min_cp = MIN_LEN3;
            default:  min_cp = MIN_LEN4;
        endcase
    end

    assign range_ok = (pv_shift >= min_cp) && (pv_shift <= CP_MAX)
                      && !((pv_shift >= SURR_LO) && (pv_shift <= SURR_HI));

    // Decode step for the byte at the head of the queue.
    always_comb
    begin
        pv_next  = pv_reg;
        len_next = len_reg;
        rem_next = rem_reg;
        err_step = err_reg;
        have     = 1'b0;
        cp       = '0;
        if (!err_reg)
        begin
            if (rem_reg == 2'd0)
            begin
                case (q.cls)
                    CLS_ASCII:
                    begin
                        have = 1'b1;
                        cp   = {{(CP_W-7){1'b0}}, q.payload};
                    end
                    CLS_LEAD2:
                    begin
                        pv_next  = {{(CP_W-5){1'b0}}, q.payload[4:0]};
                        len_next = SEQ_LEN2;
                        rem_next = 2'd1;
                    end
                    CLS_LEAD3:
                    begin
                        pv_next  = {{(CP_W-4){1'b0}}, q.payload[3:0]};
                        len_next = SEQ_LEN3;
                        rem_next = 2'd2;
                    end
                    CLS_LEAD4:
                    begin
                        pv_next  = {{(CP_W-3){1'b0}}, q.payload[2:0]};
                        len_next = SEQ_LEN4;
                        rem_next = 2'd3;
                    end
                    default: err_step = 1'b1;
                endcase
            end
            else if (q.cls != CLS_CONT)
            begin
                err_step = 1'b1;
            end
            else
            begin
                pv_next  = pv_shift;
                rem_next = rem_reg - 2'd1;
                if (rem_reg == 2'd1)
                begin
                    if (range_ok)
                    begin
                        have = 1'b1;
                        cp   = pv_shift;
                    end
                    else
                    begin
                        err_step = 1'b1;
                    end
                    pv_next  = '0;
                    len_next = '0;
                end
            end
        end
        err_next = err_step;
    end

    // Result register and end-of-string handling.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !char_ready;
        if (pop)
        begin
            if (q.last)
            begin
                out_valid_next = 1'b1;
                if (err_step || (rem_next != 2'd0))
                begin
                    out_next = '{char_code: '0, has_char: 1'b0,
                                 string_error: 1'b1, string_done: 1'b1};
                end
                else
                begin
                    out_next = '{char_code: cp, has_char: have,
                                 string_error: 1'b0, string_done: 1'b1};
                end
            end
            else if (have)
            begin
                out_valid_next = 1'b1;
                out_next = '{char_code: cp, has_char: 1'b1,
                             string_error: 1'b0, string_done: 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg        <= '0;
            len_reg       <= '0;
            rem_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop && q.last)
            begin
                // Drop all decode state at the string boundary.
                pv_reg  <= '0;
                len_reg <= '0;
                rem_reg <= '0;
                err_reg <= 1'b0;
            end
            else if (pop)
            begin
                pv_reg  <= pv_next;
                len_reg <= len_next;
                rem_reg <= rem_next;
                err_reg <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign char_valid = out_valid_reg;
    assign char_item  = out_reg;

    `U8SD_ASSERT(a_len_tracks_rem, clk, rst_n, (rem_reg != 2'd0) |-> (len_reg > {1'b0, rem_reg}))
    `U8SD_ASSERT_NEVER(a_char_with_error, clk, rst_n, out_valid_reg && out_reg.has_char && out_reg.string_error)
    `U8SD_ASSERT(a_char_in_range, clk, rst_n, (out_valid_reg && out_reg.has_char) |-> (out_reg.char_code <= CP_MAX))
    `U8SD_ASSERT(a_error_only_at_end, clk, rst_n, (out_valid_reg && out_reg.string_error) |-> out_reg.string_done)

endmodule

// ===== rtl/core/utf8_stream_decoder.sv =====
// UTF-8 stream decoder: each accepted byte is registered in the queue, then decoded
// into the result register. Throughput: one byte per clock while results are not stalled.
// Reset (rst_n low, asynchronous) empties the queue, clears the decode state and drops
// any pending result. Depends on u8sd_pkg, u8sd_front, u8sd_queue and u8sd_back.
module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = u8sd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  u8sd_pkg::byte_item_t  byte_item,
    output logic                  char_valid,
    input  logic                  char_ready,
    output u8sd_pkg::char_item_t  char_item
);
    import u8sd_pkg::*;

    // Front end: classify each byte transfer (ASCII, lead of 2/3/4, continuation,
    // bad) and push it into the queue while there is room.
    logic        push;
    logic        queue_full;
    queue_item_t push_item;
    // Back end sees the queue head; pop advances it.
    queue_head_t head;
    logic        pop;

    u8sd_front u_front (
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Queue decouples the two sides: a stalled result holds the back end,
    // while the front keeps taking bytes until the queue fills.
    u8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head      (head)
    );

    // Back end: gather continuation bits, check overlong, surrogate and range,
    // keep the sticky string error, and emit one result per code point into the output
    // register; the last byte of a string yields exactly one result, which carries the end flag.
    u8sd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item)
    );

endmodule

// ===== verif/tb_utf8_stream_decoder.sv =====
// Self-checking testbench for utf8_stream_decoder: byte transfers in, decoded characters out.
// Depends on u8sd_pkg for the transfer types and UTF-8 limits, and on the decoder RTL.
`timescale 1ns / 100ps

module tb_utf8_stream_decoder;
    import u8sd_pkg::*;

    // Random part stops once this many bytes were transferred in it; the directed
    // strings before it add about 30 more.
    localparam int RANDOM_TARGET = 920;
    // Worst case per byte is the longest idle gap from idle_cycles on each side; keep a wide margin.
    localparam int CYCLE_LIMIT   = 400000;
    // Extra cycles to wait after the last owed result before the final verdict.
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN1 = 3'd1;

    // Ways to break a string in the random part.
    typedef enum int {
        FAULT_NOISE,
        FAULT_STRAY_CONT,
        FAULT_TRUNCATE,
        FAULT_OVERLONG,
        FAULT_SURROGATE,
        FAULT_TOO_BIG,
        FAULT_BAD_LEAD
    } fault_kind_t;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    byte_item_t byte_item  = '0;
    logic       char_valid;
    logic       char_ready = 1'b0;
    char_item_t char_item;

    // Decoder shadow state, advanced once per accepted byte.
    logic [CP_W-1:0] dec_acc  = '0;
    logic [2:0]      dec_len  = SEQ_NONE;
    logic [1:0]      dec_left = 2'd0;
    logic            dec_err  = 1'b0;

    // Characters and end-of-string results still owed by the decoder, oldest first.
    char_item_t pending_chars[$];
    char_item_t predicted;
    char_item_t oldest;

    // Bytes of the string being built for transmission.
    logic [7:0] text[$];

    // When set, both sides run without idle cycles.
    bit steady = 1'b0;

    int mismatches       = 0;
    int results_checked  = 0;
    int code_points_seen = 0;
    int rejected_strings = 0;
    int bytes_accepted   = 0;
    int decoded_items    = 0;
    int strings_sent     = 0;
    int cycle_count      = 0;

    utf8_stream_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic byte_class_t classify_byte(input logic [7:0] b);
        casez (b)
            8'b0???????: return CLS_ASCII;
            8'b110?????: return CLS_LEAD2;
            8'b1110????: return CLS_LEAD3;
            8'b11110???: return CLS_LEAD4;
            8'b10??????: return CLS_CONT;
            default:     return CLS_BAD;
        endcase
    endfunction

    // Advance the shadow decoder by one byte; return 1 when the byte owes a result.
    function automatic bit decode_byte(input byte_item_t item, output char_item_t res);
        byte_class_t     cls;
        logic [CP_W-1:0] cp;
        logic [CP_W-1:0] floor_cp;
        bit              have;
        cls  = classify_byte(item.data_byte);
        cp   = '0;
        have = 1'b0;
        res  = '0;
        if (!dec_err)
        begin
            if (dec_left == 2'd0)
            begin
                case (cls)
                    CLS_ASCII:
                    begin
                        have = 1'b1;
                        cp   = CP_W'(item.data_byte[6:0]);
                    end
                    CLS_LEAD2:
                    begin
                        dec_acc  = CP_W'(item.data_byte[4:0]);
                        dec_len  = SEQ_LEN2;
                        dec_left = 2'd1;
                    end
                    CLS_LEAD3:
                    begin
                        dec_acc  = CP_W'(item.data_byte[3:0]);
                        dec_len  = SEQ_LEN3;
                        dec_left = 2'd2;
                    end
                    CLS_LEAD4:
                    begin
                        dec_acc  = CP_W'(item.data_byte[2:0]);
                        dec_len  = SEQ_LEN4;
                        dec_left = 2'd3;
                    end
                    default:
                        dec_err = 1'b1;
                endcase
            end
            else if (cls != CLS_CONT)
            begin
                dec_err = 1'b1;
            end
            else
            begin
                dec_acc  = {dec_acc[CP_W-7:0], item.data_byte[5:0]};
                dec_left = dec_left - 2'd1;
                if (dec_left == 2'd0)
                begin
                    case (dec_len)
                        SEQ_LEN2: floor_cp = MIN_LEN2;
                        SEQ_LEN3: floor_cp = MIN_LEN3;
                        default:  floor_cp = MIN_LEN4;
                    endcase
                    // Reject overlong forms, surrogates and values past the last plane.
                    if (dec_acc < floor_cp || dec_acc > CP_MAX ||
                        (dec_acc >= SURR_LO && dec_acc <= SURR_HI))
                    begin
                        dec_err = 1'b1;
                    end
                    else
                    begin
                        have = 1'b1;
                        cp   = dec_acc;
                    end
                    dec_acc = '0;
                    dec_len = SEQ_NONE;
                end
            end
        end

        if (item.end_of_string)
        begin
            // A sequence left open at the end is a fault as well.
            if (dec_err || dec_left != 2'd0)
            begin
                res.string_error = 1'b1;
            end
            else
            begin
                res.char_code = cp;
                res.has_char  = have;
            end
            res.string_done = 1'b1;
            dec_acc  = '0;
            dec_len  = SEQ_NONE;
            dec_left = 2'd0;
            dec_err  = 1'b0;
            return 1'b1;
        end
        if (have)
        begin
            res.char_code = cp;
            res.has_char  = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Checking: predict on every byte transfer, compare every character transfer
    // ------------------------------------------------------------------

    function automatic void report_field(input string field, input logic [CP_W-1:0] want,
                                         input logic [CP_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Retire the output side first; a result never leaves on the edge its byte enters.
            if (char_valid && char_ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, char_item);
                    mismatches++;
                end
                else
                begin
                    oldest = pending_chars.pop_front();
                    report_field("char_code", oldest.char_code, char_item.char_code);
                    report_field("has_char", CP_W'(oldest.has_char),
                                 CP_W'(char_item.has_char));
                    report_field("string_error", CP_W'(oldest.string_error),
                                 CP_W'(char_item.string_error));
                    report_field("string_done", CP_W'(oldest.string_done),
                                 CP_W'(char_item.string_done));
                    results_checked++;
                    if (oldest.has_char)
                        code_points_seen++;
                    if (oldest.string_error)
                        rejected_strings++;
                end
            end
            if (byte_valid && byte_ready)
            begin
                bytes_accepted++;
                if (!dec_err)
                    decoded_items++;
                if (decode_byte(byte_item, predicted))
                    pending_chars = {pending_chars, predicted};
            end
        end
    end

    // ------------------------------------------------------------------
    // Idle patterns on both sides
    // ------------------------------------------------------------------

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int idle_cycles();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sink side: hold off char_ready for random stretches.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = idle_cycles();
            if (n > 0)
            begin
                char_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            char_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drive one byte, optionally after an idle gap, and hold it until the transfer.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= '{data_byte: b, end_of_string: last};
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
    endtask

    // Send the built string, flagging its last byte, and clear it.
    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_byte(text[i], i == text.size() - 1);
        text.delete();
        strings_sent++;
    endtask

    // Add one byte at the tail of the string under construction.
    function automatic void append_byte(input logic [7:0] b);
        text = {text, b};
    endfunction

    // Append the UTF-8 form of cp at the given length; no range check, so bad forms pass too.
    function automatic void append_code(input logic [CP_W-1:0] cp, input logic [2:0] len);
        case (len)
            SEQ_LEN2:
            begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            SEQ_LEN3:
            begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            SEQ_LEN4:
            begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            default:
                append_byte({1'b0, cp[6:0]});
        endcase
    endfunction

    // Legal code point for the given length; range ends come up often.
    function automatic logic [CP_W-1:0] pick_code_point(input logic [2:0] len);
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
        logic [CP_W-1:0] cp;
        int              r;
        case (len)
            SEQ_LEN2:
            begin
                lo = MIN_LEN2;
                hi = MIN_LEN3 - 1;
            end
            SEQ_LEN3:
            begin
                lo = MIN_LEN3;
                hi = MIN_LEN4 - 1;
            end
            SEQ_LEN4:
            begin
                lo = MIN_LEN4;
                hi = CP_MAX;
            end
            default:
            begin
                lo = '0;
                hi = MIN_LEN2 - 1;
            end
        endcase
        r = $urandom_range(0, 9);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        do
            cp = CP_W'($urandom_range(lo, hi));
        while (cp >= SURR_LO && cp <= SURR_HI);
        return cp;
    endfunction

    function automatic void add_random_char();
        logic [2:0] len;
        len = 3'($urandom_range(SEQ_LEN1, SEQ_LEN4));
        append_code(pick_code_point(len), len);
    endfunction

    // Append one malformed piece of text.
    function automatic void add_fault();
        fault_kind_t kind;
        logic [2:0]  len;
        int          cut;
        kind = fault_kind_t'($urandom_range(FAULT_NOISE, FAULT_BAD_LEAD));
        len  = 3'($urandom_range(SEQ_LEN2, SEQ_LEN4));
        case (kind)
            FAULT_NOISE:
                append_byte(8'($urandom));
            FAULT_STRAY_CONT:
                append_byte({2'b10, 6'($urandom)});
            FAULT_BAD_LEAD:
                append_byte({5'b11111, 3'($urandom)});
            FAULT_TRUNCATE:
            begin
                // Drop the tail of a sequence; at the string's end this leaves it open.
                append_code(pick_code_point(len), len);
                cut = $urandom_range(1, len - 1);
                repeat (cut) void'(text.pop_back());
            end
            FAULT_OVERLONG:
                // A value legal for one length shorter is overlong here.
                append_code(pick_code_point(len - 3'd1), len);
            FAULT_SURROGATE:
                append_code(CP_W'($urandom_range(SURR_LO, SURR_HI)), SEQ_LEN3);
            default:
                append_code(CP_W'($urandom_range(CP_MAX + 1, {CP_W{1'b1}})), SEQ_LEN4);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Range ends: 1- and 2-byte min and max, 3-byte min, 4-byte max; no idle cycles on the first string.
    task automatic test_boundary_chars();
        steady = 1'b1;
        text = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF};
        send_text();
        steady = 1'b0;
        text = '{8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text();
    endtask

    // A stray continuation and a bad lead byte with later bytes dropped, a missing continuation, a cut-off tail.
    task automatic test_bad_bytes();
        text = '{8'h80, 8'hF8, 8'h41};
        send_text();
        text = '{8'hC3, 8'h41};
        send_text();
        text = '{8'hE2, 8'h82};
        send_text();
    endtask

    // Well-formed sequences whose value is overlong, a surrogate, or past the last plane.
    task automatic test_out_of_range();
        text = '{8'hC0, 8'h80};
        send_text();
        text = '{8'hED, 8'hA0, 8'h80};
        send_text();
        text = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_text();
    endtask

    // Mostly clean strings of random characters, some with one fault, some pure noise.
    task automatic test_random_text();
        int start;
        int pick;
        int nchars;
        int fault_at;
        start = bytes_accepted;
        while (bytes_accepted - start < RANDOM_TARGET)
        begin
            steady = ($urandom_range(0, 4) == 0);
            pick   = $urandom_range(0, 99);
            nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                 : $urandom_range(1, 8);
            if (pick < 10)
            begin
                repeat (nchars) append_byte(8'($urandom));
            end
            else
            begin
                fault_at = (pick < 35) ? $urandom_range(0, nchars - 1) : -1;
                for (int i = 0; i < nchars; i++)
                begin
                    if (i == fault_at)
                        add_fault();
                    else
                        add_random_char();
                end
            end
            send_text();
        end
        steady = 1'b0;
    endtask

    // Drop valid, let every owed result arrive, then give a verdict.
    task automatic finish_run();
        byte_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d strings in %0d byte transfers, %0d decoded before any fault",
                 strings_sent, bytes_accepted, decoded_items);
        $display("checked %0d results: %0d code points, %0d rejected strings",
                 results_checked, code_points_seen, rejected_strings);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_boundary_chars();
        test_bad_bytes();
        test_out_of_range();
        test_random_text();
        finish_run();
    end

    // Stop a hung run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed",
                 CYCLE_LIMIT, pending_chars.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/u8sd_pkg.sv
rtl/core/u8sd_front.sv
rtl/core/u8sd_queue.sv
rtl/core/u8sd_back.sv
rtl/core/utf8_stream_decoder.sv
verif/tb_utf8_stream_decoder.sv
